// ----- rtl/core/pva_pkg.sv -----
// pva_pkg: shared types and constants for the polyphonic voice allocator
// used by every module under rtl/core; depends on nothing
package pva_pkg;

	localparam int MAX_VOICES_DEF  = 16;
	localparam int VOICE_COUNT_RST = 16;

	localparam int NOTE_W = 7;
	localparam int AGE_W  = 32;
	localparam int CNT_W  = 5;
	localparam int MODE_W = 2;
	localparam int REQ_W  = 2;
	localparam int SEL_W  = 4;
	localparam int IDX_W  = 4;
	localparam int REG_W  = 1;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_VOICE_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_STEAL_MODE  = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_NOTE_ON  = 2'd0,
		REQ_NOTE_OFF = 2'd1,
		REQ_REL_DONE = 2'd2,
		REQ_ALL_OFF  = 2'd3
	} req_t;

	// steal mode codes; the unused code behaves as oldest
	localparam logic [MODE_W-1:0] MODE_OLDEST    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW_NOTE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH_NOTE = 2'd2;

	typedef enum logic [1:0] {
		CMP_OLDEST,
		CMP_LOW_NOTE,
		CMP_HIGH_NOTE,
		CMP_NEWEST
	} cmp_kind_t;

	typedef enum logic [1:0] {
		PASS_IDLE,
		PASS_REL,
		PASS_HELD,
		PASS_OFF
	} pass_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [AGE_W-1:0]  age;
	} entry_t;

endpackage

// ----- rtl/core/pva_vram.sv -----
// pva_vram: note and age store for all voices, one write and one registered read
// per cycle; per-voice valid bits make unwritten voices read as note 0, age 0
// depends on pva_pkg
module pva_vram #(
	parameter int DEPTH = pva_pkg::MAX_VOICES_DEF,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  pva_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr,
	output pva_pkg::entry_t     rdata
);

	pva_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	pva_pkg::entry_t  rd_s1;
	logic             rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[raddr];
	end

	// never-written voice reads as reset value
	assign rdata = rd_vld_s1 ? rd_s1 : '0;

endmodule

// ----- rtl/core/pva_cmp.sv -----
// pva_cmp: the shared candidate-versus-best compare used by every scan pass
// depends on pva_pkg
module pva_cmp (
	input  pva_pkg::cmp_kind_t kind,
	input  logic               have_best,
	input  pva_pkg::entry_t    cand,
	input  pva_pkg::entry_t    best,
	output logic               better
);

	logic age_lt;
	logic age_ge;
	logic note_lt;
	logic note_gt;
	logic note_eq;

	assign age_lt  = cand.age < best.age;
	assign age_ge  = !age_lt;
	assign note_lt = cand.note < best.note;
	assign note_gt = cand.note > best.note;
	assign note_eq = cand.note == best.note;

	always_comb begin
		case (kind)
			pva_pkg::CMP_OLDEST:    better = age_lt;
			pva_pkg::CMP_LOW_NOTE:  better = note_lt || (note_eq && age_lt);
			pva_pkg::CMP_HIGH_NOTE: better = note_gt || (note_eq && age_lt);
			pva_pkg::CMP_NEWEST:    better = age_ge;
			default:                better = age_lt;
		endcase
		if (!have_best) begin
			better = 1'b1;
		end
	end

endmodule

// ----- rtl/core/polyphonic_voice_allocator.sv -----
// polyphonic_voice_allocator: top level, sequencer, voice flags and tick counter
// depends on pva_pkg, pva_vram and pva_cmp
//
// A request beat is taken when start is high and busy is low. Note on and note
// off walk the voice table one voice per cycle through a single compare unit.
// Each pass reads every voice in use, compares the last read, closes the scan
// and then evaluates. The result beat of a one-pass request (note off, or a
// note on that finds an idle voice) follows the evaluate step of that pass. A
// note on runs up to three passes (idle voices, then releasing voices, then
// held voices for a steal). Release complete and all off give their beat the
// cycle after acceptance. busy stays high while a scan runs.
// Every request, handled or not, gives exactly one result beat: done is high for
// one cycle with voice_index, hit, stole and prev_note valid in that cycle; there
// is no backpressure, so the receiver must take the beat when it appears.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once and are
// only allowed while busy is low; writing voice_count clears every voice and the
// tick counter.
module polyphonic_voice_allocator #(
	parameter int MAX_VOICES = pva_pkg::MAX_VOICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [pva_pkg::REG_W-1:0]    cfg_idx,
	input  logic [pva_pkg::CNT_W-1:0]    cfg_data,
	// request
	input  logic                         start,
	output logic                         busy,
	input  logic [pva_pkg::REQ_W-1:0]    req_type,
	input  logic [pva_pkg::NOTE_W-1:0]   note,
	input  logic [pva_pkg::SEL_W-1:0]    voice_sel,
	// result
	output logic                         done,
	output logic [pva_pkg::IDX_W-1:0]    voice_index,
	output logic                         hit,
	output logic                         stole,
	output logic [pva_pkg::NOTE_W-1:0]   prev_note
);

	// index width, scan counter width (must reach the count itself),
	// and a common width for counter versus count compares
	localparam int IW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int KW  = IW + 1;
	localparam int CW  = (KW > pva_pkg::CNT_W) ? KW : pva_pkg::CNT_W;
	localparam int LW  = 8;
	localparam logic [pva_pkg::CNT_W-1:0] COUNT_RST =
		(MAX_VOICES < pva_pkg::VOICE_COUNT_RST) ? pva_pkg::CNT_W'(MAX_VOICES)
		                                        : pva_pkg::CNT_W'(pva_pkg::VOICE_COUNT_RST);

	// sequencer
	pva_pkg::state_t state_q, state_d;
	pva_pkg::pass_t  pass_q;
	pva_pkg::req_t   req_q;
	logic [pva_pkg::NOTE_W-1:0] note_q;

	// scan
	logic [KW-1:0]   k_q;
	logic            rd_vld_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic            best_vld_q;
	logic [IW-1:0]   best_idx_q;
	pva_pkg::entry_t best_q;

	// voice flags, tick counter and registers
	logic [MAX_VOICES-1:0] held_q;
	logic [MAX_VOICES-1:0] rel_q;
	logic [MAX_VOICES-1:0] in_use;
	logic [pva_pkg::AGE_W-1:0]  tick_q;
	logic [pva_pkg::AGE_W-1:0]  tick_nxt;
	logic [pva_pkg::CNT_W-1:0]  count_q;
	logic [pva_pkg::MODE_W-1:0] mode_q;

	// result beat
	logic                        done_q;
	logic [pva_pkg::IDX_W-1:0]   voice_index_q;
	logic                        hit_q;
	logic                        stole_q;
	logic [pva_pkg::NOTE_W-1:0]  prev_note_q;

	// control strobes from the sequencer
	logic accept;
	logic issue;
	logic restart;
	logic finish;
	logic write_hit;

	logic               cfg_count_wr;
	logic               elig;
	logic               better;
	logic               take;
	pva_pkg::cmp_kind_t kind;
	pva_pkg::entry_t    rd_entry;
	pva_pkg::entry_t    wr_entry;

	assign cfg_count_wr = cfg_we && (cfg_idx == pva_pkg::REG_VOICE_COUNT);
	assign tick_nxt     = tick_q + 1'b1;

	// voices below the count
	always_comb begin
		for (int i = 0; i < MAX_VOICES; i++) begin
			in_use[i] = CW'(i) < CW'(count_q);
		end
	end

	// ---------------------------------------------------------------- sequencer

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pva_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		issue   = 1'b0;
		restart = 1'b0;
		finish  = 1'b0;
		case (state_q)
			pva_pkg::ST_IDLE: begin
				accept = start;
				// only note on and note off need a table walk
				if (start && (req_type == pva_pkg::REQ_NOTE_ON ||
				              req_type == pva_pkg::REQ_NOTE_OFF)) begin
					state_d = pva_pkg::ST_SCAN;
				end
			end
			pva_pkg::ST_SCAN: begin
				issue = CW'(k_q) < CW'(count_q);
				// last read has come back
				if (!issue && !rd_vld_s1) begin
					state_d = pva_pkg::ST_EVAL;
				end
			end
			pva_pkg::ST_EVAL: begin
				if (best_vld_q || pass_q == pva_pkg::PASS_HELD ||
				    pass_q == pva_pkg::PASS_OFF) begin
					finish  = 1'b1;
					state_d = pva_pkg::ST_IDLE;
				end else begin
					restart = 1'b1;
					state_d = pva_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = pva_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy      = state_q != pva_pkg::ST_IDLE;
	assign write_hit = finish && best_vld_q;

	// ---------------------------------------------------------------- scan datapath

	// which voices a pass looks at
	always_comb begin
		case (pass_q)
			pva_pkg::PASS_IDLE: elig = !held_q[rd_idx_s1] && !rel_q[rd_idx_s1];
			pva_pkg::PASS_REL:  elig = !held_q[rd_idx_s1] && rel_q[rd_idx_s1];
			pva_pkg::PASS_HELD: elig = held_q[rd_idx_s1];
			pva_pkg::PASS_OFF:  elig = held_q[rd_idx_s1] && (rd_entry.note == note_q);
			default:            elig = 1'b0;
		endcase
	end

	// idle pass wants lowest age, note off wants newest, the rest follow steal mode
	always_comb begin
		case (pass_q)
			pva_pkg::PASS_IDLE: kind = pva_pkg::CMP_OLDEST;
			pva_pkg::PASS_OFF:  kind = pva_pkg::CMP_NEWEST;
			default: begin
				case (mode_q)
					pva_pkg::MODE_LOW_NOTE:  kind = pva_pkg::CMP_LOW_NOTE;
					pva_pkg::MODE_HIGH_NOTE: kind = pva_pkg::CMP_HIGH_NOTE;
					default:                 kind = pva_pkg::CMP_OLDEST;
				endcase
			end
		endcase
	end

	pva_cmp u_cmp (
		.kind      (kind),
		.have_best (best_vld_q),
		.cand      (rd_entry),
		.best      (best_q),
		.better    (better)
	);

	assign take = rd_vld_s1 && elig && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q     <= pva_pkg::PASS_IDLE;
			req_q      <= pva_pkg::REQ_NOTE_ON;
			note_q     <= '0;
			k_q        <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
			best_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= k_q[IW-1:0];
			if (accept) begin
				req_q      <= pva_pkg::req_t'(req_type);
				note_q     <= note;
				pass_q     <= (req_type == pva_pkg::REQ_NOTE_OFF) ? pva_pkg::PASS_OFF
				                                                  : pva_pkg::PASS_IDLE;
				k_q        <= '0;
				best_vld_q <= 1'b0;
			end else if (restart) begin
				// idle voices, then releasing, then held
				pass_q     <= (pass_q == pva_pkg::PASS_IDLE) ? pva_pkg::PASS_REL
				                                             : pva_pkg::PASS_HELD;
				k_q        <= '0;
				best_vld_q <= 1'b0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (take) begin
				best_vld_q <= 1'b1;
				best_idx_q <= rd_idx_s1;
				best_q     <= rd_entry;
			end
		end
	end

	// note off keeps the stored note (equal to the request note anyway)
	always_comb begin
		wr_entry.age  = tick_nxt;
		wr_entry.note = (req_q == pva_pkg::REQ_NOTE_ON) ? note_q : best_q.note;
	end

	pva_vram #(
		.DEPTH (MAX_VOICES),
		.AW    (IW)
	) u_vram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_count_wr),
		.we     (write_hit),
		.waddr  (best_idx_q),
		.wdata  (wr_entry),
		.raddr  (k_q[IW-1:0]),
		.rdata  (rd_entry)
	);

	// ---------------------------------------------------------------- flags, tick, result

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			rel_q         <= '0;
			tick_q        <= '0;
			count_q       <= COUNT_RST;
			mode_q        <= pva_pkg::MODE_OLDEST;
			done_q        <= 1'b0;
			voice_index_q <= '0;
			hit_q         <= 1'b0;
			stole_q       <= 1'b0;
			prev_note_q   <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_idx)
					pva_pkg::REG_VOICE_COUNT: begin
						// saturate to the table size, then clear the table
						count_q <= (LW'(cfg_data) > LW'(MAX_VOICES)) ?
						           pva_pkg::CNT_W'(MAX_VOICES) : cfg_data;
						held_q  <= '0;
						rel_q   <= '0;
						tick_q  <= '0;
					end
					pva_pkg::REG_STEAL_MODE: begin
						mode_q <= cfg_data[pva_pkg::MODE_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// requests with no table walk give an all-zero result beat
			if (accept && (req_type == pva_pkg::REQ_REL_DONE ||
			               req_type == pva_pkg::REQ_ALL_OFF)) begin
				done_q        <= 1'b1;
				voice_index_q <= '0;
				hit_q         <= 1'b0;
				stole_q       <= 1'b0;
				prev_note_q   <= '0;
				if (req_type == pva_pkg::REQ_ALL_OFF) begin
					rel_q  <= rel_q | (held_q & in_use);
					held_q <= held_q & ~in_use;
				end else if (pva_pkg::CNT_W'(voice_sel) < count_q &&
				             !held_q[IW'(voice_sel)]) begin
					rel_q[IW'(voice_sel)] <= 1'b0;
				end
			end

			if (finish) begin
				done_q        <= 1'b1;
				voice_index_q <= '0;
				hit_q         <= 1'b0;
				stole_q       <= 1'b0;
				prev_note_q   <= '0;
				if (best_vld_q) begin
					tick_q        <= tick_nxt;
					voice_index_q <= pva_pkg::IDX_W'(best_idx_q);
					hit_q         <= 1'b1;
					if (req_q == pva_pkg::REQ_NOTE_ON) begin
						held_q[best_idx_q] <= 1'b1;
						rel_q[best_idx_q]  <= 1'b0;
						if (pass_q == pva_pkg::PASS_HELD) begin
							stole_q     <= 1'b1;
							prev_note_q <= best_q.note;
						end
					end else begin
						held_q[best_idx_q] <= 1'b0;
						rel_q[best_idx_q]  <= 1'b1;
					end
				end
			end
		end
	end

	assign done        = done_q;
	assign voice_index = voice_index_q;
	assign hit         = hit_q;
	assign stole       = stole_q;
	assign prev_note   = prev_note_q;

endmodule

// ----- rtl/core/pva_chk.sv -----
// pva_chk: port-level checks on the voice allocator's result beats
// depends on pva_pkg; bound to polyphonic_voice_allocator at the end of this file
module pva_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [pva_pkg::IDX_W-1:0]   voice_index,
	input logic                        hit,
	input logic                        stole,
	input logic [pva_pkg::NOTE_W-1:0]  prev_note
);

	// a result beat comes back with the block ready again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (voice_index == '0 && !stole && prev_note == '0))
		else $error("miss with nonzero fields");

	// a steal is always an allocation
	a_stole_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && stole) |-> hit)
		else $error("steal without hit");

	// no beat without a request accepted or in work the cycle before
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result beat with no request");

endmodule

bind polyphonic_voice_allocator pva_chk u_pva_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.voice_index (voice_index),
	.hit         (hit),
	.stole       (stole),
	.prev_note   (prev_note)
);
